// ===== hdl/epoch_seconds_to_calendar_assert.svh =====
// assertion macros used by the checker file
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ESC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in epoch to calendar block");

// consequent must hold in the cycle after the antecedent
`define ESC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in epoch to calendar block");

`endif

// ===== hdl/esc_pkg.sv =====
package esc_pkg;

   // calendar constants
   localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
   localparam logic [6:0]  EPOCH_MOD100     = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400     = 9'd370;
   localparam logic [6:0]  YEAR_MOD100_LAST = 7'd99;
   localparam logic [8:0]  YEAR_MOD400_LAST = 9'd399;
   localparam logic [8:0]  YEAR_DAYS        = 9'd365;
   localparam logic [8:0]  LEAP_YEAR_DAYS   = 9'd366;
   localparam logic [6:0]  SECS_PER_MIN     = 7'd60;
   localparam logic [6:0]  HOURS_PER_DAY    = 7'd24;
   localparam logic [3:0]  MONTH_JAN        = 4'd0;
   localparam logic [3:0]  MONTH_FEB        = 4'd1;
   localparam logic [3:0]  MONTH_LAST       = 4'd11;

   // reciprocals, exact for any 32-bit x: x / 60 = (x * RECIP_60) >> 37,
   // x / 24 = (x * RECIP_24) >> 36
   localparam logic [31:0] RECIP_60         = 32'h8888_8889;
   localparam logic [31:0] RECIP_24         = 32'hAAAA_AAAB;

   // channel payloads
   typedef struct packed {
      logic [31:0] epoch_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rsp_payload_type;

   // microcode
   typedef enum logic [2:0] {
      OP_WAIT,
      OP_MUL,
      OP_DIV,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      DST_SEC,
      DST_MIN,
      DST_HOUR
   } dest_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      op_type   op;
      dest_type dest;
      upc_type  next;
   } uword_type;

   localparam upc_type UPC_WAIT     = 4'd0;
   localparam upc_type UPC_MUL_SEC  = 4'd1;
   localparam upc_type UPC_DIV_SEC  = 4'd2;
   localparam upc_type UPC_MUL_MIN  = 4'd3;
   localparam upc_type UPC_DIV_MIN  = 4'd4;
   localparam upc_type UPC_MUL_HOUR = 4'd5;
   localparam upc_type UPC_DIV_HOUR = 4'd6;
   localparam upc_type UPC_YEAR     = 4'd7;
   localparam upc_type UPC_MONTH    = 4'd8;
   localparam upc_type UPC_EMIT     = 4'd9;

   // control store
   function automatic uword_type ucode(upc_type pc);
      uword_type w;
      w = '{op: OP_WAIT, dest: DST_SEC, next: UPC_WAIT};
      case (pc)
         UPC_WAIT:     w = '{op: OP_WAIT,  dest: DST_SEC,  next: UPC_MUL_SEC};
         UPC_MUL_SEC:  w = '{op: OP_MUL,   dest: DST_SEC,  next: UPC_DIV_SEC};
         UPC_DIV_SEC:  w = '{op: OP_DIV,   dest: DST_SEC,  next: UPC_MUL_MIN};
         UPC_MUL_MIN:  w = '{op: OP_MUL,   dest: DST_MIN,  next: UPC_DIV_MIN};
         UPC_DIV_MIN:  w = '{op: OP_DIV,   dest: DST_MIN,  next: UPC_MUL_HOUR};
         UPC_MUL_HOUR: w = '{op: OP_MUL,   dest: DST_HOUR, next: UPC_DIV_HOUR};
         UPC_DIV_HOUR: w = '{op: OP_DIV,   dest: DST_HOUR, next: UPC_YEAR};
         UPC_YEAR:     w = '{op: OP_YEAR,  dest: DST_SEC,  next: UPC_MONTH};
         UPC_MONTH:    w = '{op: OP_MONTH, dest: DST_SEC,  next: UPC_EMIT};
         UPC_EMIT:     w = '{op: OP_EMIT,  dest: DST_SEC,  next: UPC_WAIT};
         default:      w = '{op: OP_WAIT,  dest: DST_SEC,  next: UPC_WAIT};
      endcase
      return w;
   endfunction

   // days in month, month counted from zero
   function automatic logic [4:0] month_days(logic [3:0] mon, logic leap);
      logic [4:0] d;
      case (mon)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   d = 5'd30;
         MONTH_FEB:                                 d = leap ? 5'd29 : 5'd28;
         default:                                   d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ===== hdl/esc_if.sv =====
// input item channel
interface esc_req_if;
   logic                     valid;
   logic                     ready;
   esc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// result item channel
interface esc_rsp_if;
   logic                     valid;
   logic                     ready;
   esc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/epoch_seconds_to_calendar.sv =====
// Converts a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 UTC into Gregorian
// year, month, day, hour, minute and second. One item is converted at a time: req_bus.ready
// is high only while the sequencer waits for an item. An item passes through three divisions
// (by 60, 60 and 24, each a reciprocal multiply step and a quotient and remainder step),
// then takes off one whole year per cycle (up to 136) and then one whole month per cycle
// (up to 11), each loop ending with a closing step, and is then handed to the result register.
// The latest dates leave few months, so years and months together stay at or under 146.
// The next item is accepted at the earliest in the cycle after the hand-over; the hand-over
// waits while the result register still holds an item that has not been taken. The result
// register holds a finished item while the next one is accepted and converted. Control comes
// from a small microcode table in esc_pkg stepped by a program counter.
module epoch_seconds_to_calendar (
   input  logic      clock,
   input  logic      reset,
   esc_req_if.sink   req_bus,
   esc_rsp_if.source rsp_bus
);
   import esc_pkg::*;

   upc_type         upc_ff, upc_in;
   logic [31:0]     t_ff, t_in;
   logic [27:0]     prod_ff, prod_in;
   logic [4:0]      hour_ff, hour_in;
   logic [5:0]      min_ff, min_in;
   logic [5:0]      sec_ff, sec_in;
   logic [11:0]     year_ff, year_in;
   logic [6:0]      mod100_ff, mod100_in;
   logic [8:0]      mod400_ff, mod400_in;
   logic [3:0]      mon_ff, mon_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   uword_type   uw;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [6:0]  divisor;
   logic [31:0] recip;
   logic [31:0] quot;
   logic [5:0]  rem;
   logic        rsp_free;

   // decode and shared datapath terms
   always_comb begin
      uw       = ucode(upc_ff);
      leap     = (mod400_ff[1:0] == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));
      ylen     = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
      mlen     = month_days(mon_ff, leap);
      divisor  = (uw.dest == DST_HOUR) ? HOURS_PER_DAY : SECS_PER_MIN;
      recip    = (uw.dest == DST_HOUR) ? RECIP_24 : RECIP_60;
      quot     = (uw.dest == DST_HOUR) ? {4'd0, prod_ff} : {5'd0, prod_ff[27:1]};
      rem      = 6'(t_ff - quot * {25'd0, divisor});
      rsp_free = !rsp_valid_ff || rsp_bus.ready;
   end

   assign req_bus.ready   = (uw.op == OP_WAIT);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // microcoded sequencer step
   always_comb begin
      upc_in       = upc_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      year_in      = year_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      mon_in       = mon_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      case (uw.op)
         OP_WAIT: begin
            if (req_bus.valid) begin
               t_in      = req_bus.payload.epoch_seconds;
               year_in   = EPOCH_YEAR;
               mod100_in = EPOCH_MOD100;
               mod400_in = EPOCH_MOD400;
               mon_in    = MONTH_JAN;
               upc_in    = uw.next;
            end
         end
         OP_MUL: begin
            // reciprocal product, kept from bit 36 up
            prod_in = 28'(({32'd0, t_ff} * {32'd0, recip}) >> 36);
            upc_in  = uw.next;
         end
         OP_DIV: begin
            // quotient replaces the count, remainder goes to its field
            t_in = quot;
            case (uw.dest)
               DST_SEC:  sec_in  = rem;
               DST_MIN:  min_in  = rem;
               DST_HOUR: hour_in = rem[4:0];
               default:  sec_in  = rem;
            endcase
            upc_in = uw.next;
         end
         OP_YEAR: begin
            // take off one whole year per cycle
            if (t_ff < {23'd0, ylen}) begin
               upc_in = uw.next;
            end else begin
               t_in      = t_ff - {23'd0, ylen};
               year_in   = year_ff + 12'd1;
               mod100_in = (mod100_ff == YEAR_MOD100_LAST) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == YEAR_MOD400_LAST) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         OP_MONTH: begin
            // take off one whole month per cycle, december never
            if ((mon_ff == MONTH_LAST) || (t_ff < {27'd0, mlen})) begin
               upc_in = uw.next;
            end else begin
               t_in   = t_ff - {27'd0, mlen};
               mon_in = mon_ff + 4'd1;
            end
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_in.year   = year_ff;
               rsp_in.month  = mon_ff + 4'd1;
               rsp_in.day    = t_ff[4:0] + 5'd1;
               rsp_in.hour   = hour_ff;
               rsp_in.minute = min_ff;
               rsp_in.second = sec_ff;
               rsp_valid_in  = 1'b1;
               upc_in        = uw.next;
            end
         end
         default: begin
            upc_in = UPC_WAIT;
         end
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff      <= t_in;
      prod_ff   <= prod_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      sec_ff    <= sec_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mon_ff    <= mon_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== hdl/esc_checker.sv =====
module esc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input esc_pkg::rsp_payload_type rsp_payload
);
   `include "epoch_seconds_to_calendar_assert.svh"

   logic date_ok;
   logic time_ok;

   // field range terms
   assign date_ok = (rsp_payload.month >= 4'd1) && (rsp_payload.month <= 4'd12) &&
                    (rsp_payload.day >= 5'd1) &&
                    (rsp_payload.year >= 12'd1970) && (rsp_payload.year <= 12'd2106);
   assign time_ok = (rsp_payload.hour < 5'd24) && (rsp_payload.minute < 6'd60) &&
                    (rsp_payload.second < 6'd60);

   // a stalled result holds
   `ESC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // one item at a time
   `ESC_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

   // date fields in range
   `ESC_ASSERT_SAME(a_date_range, rsp_valid, date_ok)

   // time of day in range
   `ESC_ASSERT_SAME(a_time_range, rsp_valid, time_ok)

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// ===== sim/epoch_seconds_to_calendar_test.sv =====
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_test;
   import esc_pkg::*;

   localparam int unsigned RANDOM_PER_PHASE = 475;
   localparam int unsigned SECS_PER_DAY     = 86400;
   localparam int unsigned LAST_WHOLE_DAY   = 49709;
   localparam int unsigned DRAIN_CYCLES     = 400;

   logic clock;
   logic reset;

   esc_req_if req_if ();
   esc_rsp_if rsp_if ();

   epoch_seconds_to_calendar dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // items waiting to be sent, and dates still owed by the block
   logic [31:0]     epoch_backlog[$];
   rsp_payload_type calendar_due[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   logic        req_taken;
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned dates_checked;
   int unsigned earliest_year;
   int unsigned latest_year;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // gregorian leap rule
   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // seconds since 1970 to calendar date and time of day
   function automatic rsp_payload_type calendar_of(logic [31:0] secs);
      int unsigned     month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      rsp_payload_type date;
      int unsigned     t;
      int unsigned     days;
      int unsigned     yr;
      int unsigned     mon;
      bit              leap;
      t = secs;
      date.second = 6'(t % 60);
      t = t / 60;
      date.minute = 6'(t % 60);
      t = t / 60;
      date.hour = 5'(t % 24);
      days = t / 24;
      // take off whole years
      yr = 1970;
      while (days >= (leap_year(yr) ? 366 : 365)) begin
         days = days - (leap_year(yr) ? 366 : 365);
         yr++;
      end
      // then whole months, february longer in leap years
      leap = leap_year(yr);
      mon = 0;
      while (mon < 11 && days >= month_len[mon] + ((mon == 1 && leap) ? 1 : 0)) begin
         days = days - (month_len[mon] + ((mon == 1 && leap) ? 1 : 0));
         mon++;
      end
      date.year  = 12'(yr);
      date.month = 4'(mon + 1);
      date.day   = 5'(days + 1);
      return date;
   endfunction

   // one line per mismatch
   task automatic note_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // item driver, changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (epoch_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= '{epoch_seconds: epoch_backlog.pop_front()};
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            want = calendar_of(req_if.payload.epoch_seconds);
            calendar_due.push_back(want);
            items_sent++;
            if (want.year < earliest_year) earliest_year = want.year;
            if (want.year > latest_year) latest_year = want.year;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (calendar_due.size() == 0) begin
               note_mismatch("unexpected result, year", 0, got.year);
            end else begin
               want = calendar_due.pop_front();
               dates_checked++;
               if (got.year != want.year) note_mismatch("year", want.year, got.year);
               if (got.month != want.month) note_mismatch("month", want.month, got.month);
               if (got.day != want.day) note_mismatch("day", want.day, got.day);
               if (got.hour != want.hour) note_mismatch("hour", want.hour, got.hour);
               if (got.minute != want.minute) note_mismatch("minute", want.minute, got.minute);
               if (got.second != want.second) note_mismatch("second", want.second, got.second);
            end
         end
      end
   end

   // stimulus and phase control
   initial begin
      int unsigned idle_plan[4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{16, 16}};
      logic [31:0] directed[$] = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd68255999,
         32'd68256000, 32'd946684799, 32'd946684800, 32'd951782400, 32'd978307199,
         32'd4107455999, 32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
      int unsigned days;
      logic [31:0] secs;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches     = 0;
      items_sent     = 0;
      dates_checked  = 0;
      earliest_year  = 4095;
      latest_year    = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes, unit rollovers, year and leap day edges
      foreach (directed[i]) epoch_backlog.push_back(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_plan[phase][0];
         recv_stall_pct = idle_plan[phase][1];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            case ($urandom_range(9, 0))
               // small counts stay within the first days of 1970
               0, 1: secs = $urandom_range(32'h000F_FFFF, 0);
               // midnight edges, where day, month and year roll over
               2, 3, 4: begin
                  days = $urandom_range(LAST_WHOLE_DAY, 0);
                  secs = days * SECS_PER_DAY + ($urandom_range(1, 0) ? SECS_PER_DAY - 1 : 0);
               end
               default: secs = $urandom();
            endcase
            epoch_backlog.push_back(secs);
         end
         // hold off until the block has handed back every date
         while (epoch_backlog.size() != 0 || req_if.valid || calendar_due.size() != 0)
            @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("converted %0d items and checked %0d dates, years %0d to %0d,",
               items_sent, dates_checked, earliest_year, latest_year);
      $display("with sender gaps and result stalls in four mixes, including none");
      if (mismatches == 0 && calendar_due.size() == 0) begin
         $display("epoch_seconds_to_calendar_test: clean");
      end else begin
         $display("epoch_seconds_to_calendar_test: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("timeout with %0d dates outstanding", calendar_due.size());
      $display("epoch_seconds_to_calendar_test: errors");
      $finish;
   end

endmodule
